>>> hdl/median_filter_3x3_core_defines.svh
// Assertion macros for the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mf3_pkg.sv
// Shared constants for the 3x3 median filter.
package mf3_pkg;

  localparam int MAX_WIDTH_DEF   = 512;
  localparam int PIXEL_BITS_DEF  = 8;

  localparam int CFG_WIDTH_BITS  = 10;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 13;
  localparam int ROW_BITS        = 13;
  localparam int MAX_HEIGHT      = 4096;

  localparam logic [CFG_WIDTH_BITS-1:0]  RESET_WIDTH  = CFG_WIDTH_BITS'(260);
  localparam logic [CFG_HEIGHT_BITS-1:0] RESET_HEIGHT = CFG_HEIGHT_BITS'(260);

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic OP_PIXEL = 1'b0;

  localparam int WIN_SIDE = 3;
  localparam int WIN_TAPS = WIN_SIDE * WIN_SIDE;

endpackage

>>> hdl/mf3_ifs.sv
// Valid/ready channel interfaces for pixel input, median output and configuration.
interface mf3_in_if #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, operation, pixel, input ready);
  modport sink   (input valid, operation, pixel, output ready);
endinterface

interface mf3_out_if #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] median;
  logic                  last;

  modport source (output valid, median, last, input ready);
  modport sink   (input valid, median, last, output ready);
endinterface

interface mf3_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mf3_pkg::CFG_IDX_BITS-1:0]   index;
  logic [mf3_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/mf3_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module mf3_ram #(
  parameter int WIDTH = mf3_pkg::PIXEL_BITS_DEF,
  parameter int DEPTH = mf3_pkg::MAX_WIDTH_DEF,
  localparam int AddrBits = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                re,
  input  logic [AddrBits-1:0] raddr,
  output logic [WIDTH-1:0]    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mf3_median9.sv
// Rank-based median of nine pixels: every tap counts the taps below and up to it.
module mf3_median9 #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic [PIXEL_BITS-1:0] taps [mf3_pkg::WIN_TAPS],
  output logic [PIXEL_BITS-1:0] median
);

  localparam int NTaps    = mf3_pkg::WIN_TAPS;
  localparam int CntBits  = $clog2(NTaps + 1);
  localparam int MidRank  = NTaps / 2;

  always_comb begin
    logic [NTaps-1:0]   below_vec;
    logic [NTaps-1:0]   upto_vec;
    logic [CntBits-1:0] below_cnt;
    logic [CntBits-1:0] upto_cnt;
    median = '0;
    for (int i = 0; i < NTaps; i++) begin
      for (int j = 0; j < NTaps; j++) begin
        below_vec[j] = taps[j] <  taps[i];
        upto_vec[j]  = taps[j] <= taps[i];
      end
      below_cnt = CntBits'($countones(below_vec));
      upto_cnt  = CntBits'($countones(upto_vec));
      // every tap that qualifies holds the same value, so OR them together
      if (below_cnt <= CntBits'(MidRank) && upto_cnt >= CntBits'(MidRank + 1)) begin
        median = median | taps[i];
      end
    end
  end

endmodule

>>> hdl/median_filter_3x3_core.sv
// Top level of the streaming 3x3 median filter with two line stores.
//
//  Channel  Role    Payload                      Accepted when
//  -------  ------  ---------------------------  ---------------------
//  in_ch    sink    operation, pixel             valid && ready
//  out_ch   source  median, last                 valid && ready
//  cfg_ch   sink    index, data (width, height)  valid && ready (ready is always high)
//
// Sustains one item per clock unless the output stalls; the rate is set by the
// line stores, which take one read and one write per item.  A result passes
// through the input stage, window stage and median stage before it leaves.
// Reset is synchronous and active low; it clears the position counters, the
// stage valid flags and the window, and sets the frame to 260 by 260.  The line
// stores are not cleared and need no clearing pass.
// A stalled output holds its result and back-pressures through the two stages.
`include "median_filter_3x3_core_defines.svh"

module median_filter_3x3_core #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mf3_in_if.sink      in_ch,
  mf3_out_if.source   out_ch,
  mf3_cfg_if.sink     cfg_ch
);

  localparam int ColBits  = $clog2(MAX_WIDTH);
  localparam int WcmpBits = ($clog2(MAX_WIDTH + 1) > mf3_pkg::CFG_WIDTH_BITS) ?
                            $clog2(MAX_WIDTH + 1) : mf3_pkg::CFG_WIDTH_BITS;
  localparam int RowBits  = mf3_pkg::ROW_BITS;
  localparam int Side     = mf3_pkg::WIN_SIDE;
  localparam int Taps     = mf3_pkg::WIN_TAPS;

  typedef struct packed {
    logic [ColBits-1:0]    ci;
    logic [PIXEL_BITS-1:0] x;
    logic                  ri_ge1;
    logic                  ri_ge2;
    logic                  res_a;   // end-of-row result from the previous row
    logic                  res_b;   // result for the column left of this item
    logic                  keep0;   // keep the left window column
    logic                  last;
  } s1_item_t;

  // ---------------------------------------------------------------- config
  logic [mf3_pkg::CFG_WIDTH_BITS-1:0]  frame_width_r;
  logic [mf3_pkg::CFG_HEIGHT_BITS-1:0] frame_height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mf3_pkg::RESET_WIDTH;
      frame_height_r <= mf3_pkg::RESET_HEIGHT;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        mf3_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_ch.data[mf3_pkg::CFG_WIDTH_BITS-1:0];
        end
        mf3_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_ch.data[mf3_pkg::CFG_HEIGHT_BITS-1:0];
        end
        default: begin
          // unknown register: drop the write
        end
      endcase
    end
  end

  // clamp the frame size to its legal range
  logic [WcmpBits-1:0] fw_ext;
  logic [WcmpBits-1:0] w_eff;
  logic [RowBits-1:0]  h_eff;
  logic [RowBits-1:0]  h_plus1;

  assign fw_ext = WcmpBits'(frame_width_r);

  always_comb begin
    priority if (fw_ext == '0) begin
      w_eff = WcmpBits'(1);
    end else if (fw_ext > WcmpBits'(MAX_WIDTH)) begin
      w_eff = WcmpBits'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    priority if (frame_height_r == '0) begin
      h_eff = RowBits'(1);
    end else if (RowBits'(frame_height_r) > RowBits'(mf3_pkg::MAX_HEIGHT)) begin
      h_eff = RowBits'(mf3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = RowBits'(frame_height_r);
    end
  end

  assign h_plus1 = h_eff + RowBits'(1);

  // ---------------------------------------------------------------- handshake
  logic s1_v_r;
  logic s2_v_r;
  logic out_v_r;
  logic s1_fire;
  logic s3_load;
  logic in_accept;

  assign s3_load   = s2_v_r && (!out_v_r || out_ch.ready);
  assign s1_fire   = s1_v_r && (!s2_v_r || s3_load);
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign in_accept = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------- position
  logic [ColBits-1:0]  cc_r;
  logic [RowBits-1:0]  rc_r;
  logic [ColBits-1:0]  cc_nxt;
  logic [RowBits-1:0]  rc_nxt;
  logic [ColBits-1:0]  c1;
  logic [RowBits-1:0]  r1;
  logic [ColBits-1:0]  ci;
  logic [RowBits-1:0]  ri;
  logic [WcmpBits-1:0] ci_inc;
  logic                col_wrap;
  logic                restart;
  logic                row_end;
  logic                ci_is0;
  logic                ci_is1;
  logic                acc_last;
  s1_item_t            s1_nxt;

  always_comb begin
    // wrap a column beyond the width, then restart past the flush region
    col_wrap = WcmpBits'(cc_r) >= w_eff;
    c1       = col_wrap ? '0 : cc_r;
    r1       = col_wrap ? rc_r + RowBits'(1) : rc_r;
    restart  = (r1 > h_plus1) || (r1 == h_plus1 && c1 != '0);
    ci       = restart ? '0 : c1;
    ri       = restart ? '0 : r1;

    ci_is0   = ci == '0;
    ci_is1   = ci == ColBits'(1);
    acc_last = ci_is0 && ri == h_plus1;

    s1_nxt.ci     = ci;
    s1_nxt.x      = (in_ch.operation == mf3_pkg::OP_PIXEL && ri < h_eff) ?
                    in_ch.pixel : '0;
    s1_nxt.ri_ge1 = ri != '0;
    s1_nxt.ri_ge2 = ri > RowBits'(1);
    s1_nxt.res_a  = ci_is0 && s1_nxt.ri_ge2;
    s1_nxt.res_b  = !ci_is0 && s1_nxt.ri_ge1;
    s1_nxt.keep0  = s1_nxt.res_a ? (w_eff > WcmpBits'(1)) : !ci_is1;
    s1_nxt.last   = acc_last;

    // advance the position for the next item
    ci_inc  = WcmpBits'(ci) + WcmpBits'(1);
    row_end = ci_inc >= w_eff;
    if (acc_last) begin
      cc_nxt = '0;
      rc_nxt = '0;
    end else if (row_end) begin
      cc_nxt = '0;
      rc_nxt = ri + RowBits'(1);
    end else begin
      cc_nxt = ColBits'(ci_inc);
      rc_nxt = ri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      rc_r <= '0;
    end else if (in_accept) begin
      cc_r <= cc_nxt;
      rc_r <= rc_nxt;
    end
  end

  // ---------------------------------------------------------------- input stage
  s1_item_t              s1_r;
  logic                  s1_fwd_r;
  logic [PIXEL_BITS-1:0] s1_fwd_up_r;
  logic [PIXEL_BITS-1:0] s1_fwd_mid_r;
  logic [PIXEL_BITS-1:0] up_rdata;
  logic [PIXEL_BITS-1:0] mid_rdata;
  logic [PIXEL_BITS-1:0] top_raw;
  logic [PIXEL_BITS-1:0] mid_raw;

  // an item leaving as the next one arrives at the same column (width one)
  // writes the line stores too late for the read: forward its write data
  assign top_raw = s1_fwd_r ? s1_fwd_up_r  : up_rdata;
  assign mid_raw = s1_fwd_r ? s1_fwd_mid_r : mid_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r         <= s1_nxt;
      s1_fwd_r     <= s1_fire && (s1_r.ci == ci);
      s1_fwd_up_r  <= mid_raw;
      s1_fwd_mid_r <= s1_r.x;
    end
  end

  mf3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_r.ci),
    .wdata (mid_raw),
    .re    (in_accept),
    .raddr (ci),
    .rdata (up_rdata)
  );

  mf3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_r.ci),
    .wdata (s1_r.x),
    .re    (in_accept),
    .raddr (ci),
    .rdata (mid_rdata)
  );

  // ---------------------------------------------------------------- window stage
  logic [PIXEL_BITS-1:0] win_r       [Taps];
  logic [PIXEL_BITS-1:0] new_col     [Side];
  logic [PIXEL_BITS-1:0] s2_taps_nxt [Taps];
  logic [PIXEL_BITS-1:0] s2_taps_r   [Taps];
  logic                  s2_last_r;

  always_comb begin
    new_col[0] = s1_r.ri_ge2 ? top_raw : '0;
    new_col[1] = s1_r.ri_ge1 ? mid_raw : '0;
    new_col[2] = s1_r.x;
    // both result kinds take the two newest stored columns; the end-of-row
    // result pads the right column, the in-row result takes the new column
    for (int r = 0; r < Side; r++) begin
      s2_taps_nxt[r*Side]     = s1_r.keep0 ? win_r[r*Side + 1] : '0;
      s2_taps_nxt[r*Side + 1] = win_r[r*Side + 2];
      s2_taps_nxt[r*Side + 2] = s1_r.res_b ? new_col[r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Taps; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_fire) begin
      // shift the window one column left and append the new column
      for (int r = 0; r < Side; r++) begin
        win_r[r*Side]     <= win_r[r*Side + 1];
        win_r[r*Side + 1] <= win_r[r*Side + 2];
        win_r[r*Side + 2] <= new_col[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_fire) begin
      s2_v_r <= s1_r.res_a || s1_r.res_b;
    end else if (s3_load) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_taps_r <= s2_taps_nxt;
      s2_last_r <= s1_r.last;
    end
  end

  // ---------------------------------------------------------------- median stage
  logic [PIXEL_BITS-1:0] median_nxt;
  logic [PIXEL_BITS-1:0] out_median_r;
  logic                  out_last_r;

  mf3_median9 #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median9 (
    .taps   (s2_taps_r),
    .median (median_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_median_r <= median_nxt;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.median = out_median_r;
  assign out_ch.last   = out_last_r;

  // ---------------------------------------------------------------- assertions
  `MF3_ASSERT_NEXT(a_frame_restart, in_accept && acc_last, cc_r == '0 && rc_r == '0, "position not restarted after last item")
  `MF3_ASSERT_NEXT(a_s2_holds, s2_v_r && out_ch.valid && !out_ch.ready, s2_v_r, "window stage result lost under stall")
  `MF3_ASSERT_NOW(a_out_source, $rose(out_v_r), $past(s2_v_r), "result shown without a window stage item")

endmodule
